/* src/lmk_pkg.sv */
package lmk_pkg;

  // Default sizing of the recency list.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 8;

  // Fixed field widths of the stream payloads.
  localparam int KEY_FIELD_W = 8;
  localparam int KB_W        = 36;
  localparam int PCT_W       = 7;
  localparam int CNT_FIELD_W = 5;
  localparam int CFG_IDX_W   = 2;

  // Scaled dividend avail_kb * 100 fits in this many bits.
  localparam int DIVD_W = KB_W + 7;

  // Reset values of the thresholds.
  localparam logic [PCT_W-1:0] KILL_RESET = 7'd10;
  localparam logic [PCT_W-1:0] WARN_RESET = 7'd20;
  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KILL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN = 2'd1;

  typedef enum logic [1:0] {
    ACT_TOUCH  = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_WARN     = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_CRITICAL = 3'd3,
    ST_INVALID  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

endpackage

/* src/lru_low_memory_killer_core.sv */
// Recency list of application keys with a memory pressure check. A touch
// request moves its key to the tail of the list (or appends it), a remove
// request deletes it, and a check request computes mem_avail*100/mem_total,
// saturated at 100, evicting the oldest key below kill_percent and warning
// below warn_percent. Every request gives exactly one result. The block
// takes one request at a time and drops in_tready until its result is
// loaded into the output register. The list lives in a single-port memory
// with a registered read, so each entry walked takes a read state and then
// a compare or write state. A check skips the divide for a zero total or a
// saturating percent, and walks the list when it evicts. The divide runs
// one quotient bit per cycle through the one shared subtractor (seven
// steps). There is no clearing pass after reset; only entries below the
// entry count are read.
module lru_low_memory_killer_core
  import lmk_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // tdata: app_key[7:0], mem_total[43:8], mem_avail[79:44].
  input  logic [79:0]          in_tdata,
  // tuser: action[1:0].
  input  logic [1:0]           in_tuser,
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // tdata: victim_key[7:0], free_percent[14:8], entry_count[19:15], zero[23:20].
  output logic [23:0]          out_tdata,
  // tuser: status[2:0].
  output logic [2:0]           out_tuser,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data
);

  localparam int KW = KEY_BITS;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_FIND_RD  = 11'b000_0000_0010,
    S_FIND_CMP = 11'b000_0000_0100,
    S_SHIFT_RD = 11'b000_0000_1000,
    S_SHIFT_WR = 11'b000_0001_0000,
    S_CHECK    = 11'b000_0010_0000,
    S_SCALE    = 11'b000_0100_0000,
    S_DIV      = 11'b000_1000_0000,
    S_DECIDE   = 11'b001_0000_0000,
    S_EVICT    = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [KB_W-1:0]     total_r, total_nxt;
  logic [KB_W-1:0]     avail_r, avail_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [DIVD_W-1:0]   rem_r, rem_nxt;
  logic [DIVD_W-1:0]   div_r, div_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [PCT_W-1:0]    pct_r, pct_nxt;
  status_t             status_r, status_nxt;
  logic [KW-1:0]       victim_r, victim_nxt;
  logic [PCT_W-1:0]    kill_r, kill_nxt;
  logic [PCT_W-1:0]    warn_r, warn_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;
  status_t             out_status_r, out_status_nxt;

  // List memory with a registered read port.
  logic [KW-1:0]       mem [MAX_ENTRIES];
  logic [KW-1:0]       rd_data_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [KW-1:0]       mem_wdata;

  // Shared subtractor used for compares and divide steps.
  logic [DIVD_W-1:0]   unit_a, unit_b;
  logic [DIVD_W:0]     unit_diff;
  logic                unit_borrow;

  logic [31:0]         key_wide, victim_wide, count_wide;
  logic [KW-1:0]       key_in;
  logic [CW-1:0]       idx_inc, count_dec;
  logic                out_load;

  assign key_wide    = 32'(in_tdata[7:0]);
  assign key_in      = key_wide[KW-1:0];
  assign idx_inc     = idx_r + CNT_ONE;
  assign count_dec   = count_r - CNT_ONE;
  assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_borrow = unit_diff[DIVD_W];
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Operand select for the shared subtractor.
  always_comb begin
    if (state_r == S_DIV) begin
      unit_a = rem_r;
      unit_b = div_r;
    end else begin
      unit_a = DIVD_W'(avail_r);
      unit_b = DIVD_W'(total_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    key_nxt    = key_r;
    total_nxt  = total_r;
    avail_nxt  = avail_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    step_nxt   = step_r;
    pct_nxt    = pct_r;
    status_nxt = status_r;
    victim_nxt = victim_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_raddr  = idx_r[AW-1:0];
    mem_wdata  = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = action_t'(in_tuser);
          key_nxt    = key_in;
          total_nxt  = in_tdata[43:8];
          avail_nxt  = in_tdata[79:44];
          idx_nxt    = '0;
          pct_nxt    = '0;
          status_nxt = ST_OK;
          victim_nxt = '0;
          unique case (action_t'(in_tuser))
            ACT_TOUCH, ACT_REMOVE: state_nxt = S_FIND_RD;
            ACT_CHECK:             state_nxt = S_CHECK;
            default:               state_nxt = S_OUT;
          endcase
        end
      end

      // Read the next entry, or act on a miss at the end of the list.
      S_FIND_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_OUT;
          if (act_r == ACT_TOUCH) begin
            if (count_r == CNT_MAX) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              count_nxt = count_r + CNT_ONE;
            end
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (rd_data_r == key_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FIND_RD;
        end
      end

      // Close the gap at idx one entry at a time.
      S_SHIFT_RD: begin
        if (idx_inc < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
          state_nxt = S_SHIFT_WR;
        end else begin
          state_nxt = S_OUT;
          if (act_r == ACT_TOUCH) begin
            mem_we    = 1'b1;
            mem_waddr = count_dec[AW-1:0];
          end else begin
            count_nxt = count_dec;
          end
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        idx_nxt   = idx_inc;
        state_nxt = S_SHIFT_RD;
      end

      // Reject a zero total and saturate when avail is at least total.
      S_CHECK: begin
        if (total_r == '0) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_OUT;
        end else if (!unit_borrow) begin
          pct_nxt   = PCT_FULL;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCALE;
        end
      end

      // Scale avail by 100 as 64 + 32 + 4.
      S_SCALE: begin
        rem_nxt   = (DIVD_W'(avail_r) << 6) + (DIVD_W'(avail_r) << 5)
                  + (DIVD_W'(avail_r) << 2);
        div_nxt   = DIVD_W'(total_r) << 6;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end

      // Restoring divide, one quotient bit per cycle, MSB first.
      S_DIV: begin
        if (!unit_borrow) begin
          rem_nxt = unit_diff[DIVD_W-1:0];
        end
        pct_nxt  = {pct_r[PCT_W-2:0], ~unit_borrow};
        div_nxt  = div_r >> 1;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(PCT_W - 1)) begin
          state_nxt = S_DECIDE;
        end
      end

      // Kill takes priority over warn.
      S_DECIDE: begin
        state_nxt = S_OUT;
        if (pct_r < kill_r) begin
          if (count_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = S_EVICT;
          end else begin
            status_nxt = ST_CRITICAL;
          end
        end else if (pct_r < warn_r) begin
          status_nxt = ST_WARN;
        end
      end

      S_EVICT: begin
        victim_nxt = rd_data_r;
        status_nxt = ST_EVICTED;
        idx_nxt    = '0;
        state_nxt  = S_SHIFT_RD;
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register and configuration writes.
  assign victim_wide = 32'(victim_r);
  assign count_wide  = 32'(count_r);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_data_nxt   = {4'b0000, count_wide[CNT_FIELD_W-1:0], pct_r, victim_wide[7:0]};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    kill_nxt = kill_r;
    warn_nxt = warn_r;
    if (cfg_valid) begin
      if (cfg_index == REG_KILL) begin
        kill_nxt = cfg_data;
      end else if (cfg_index == REG_WARN) begin
        warn_nxt = cfg_data;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      kill_r      <= KILL_RESET;
      warn_r      <= WARN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      kill_r      <= kill_nxt;
      warn_r      <= warn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    total_r      <= total_nxt;
    avail_r      <= avail_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    step_r       <= step_nxt;
    pct_r        <= pct_nxt;
    status_r     <= status_nxt;
    victim_r     <= victim_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // List memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  // The list never holds more keys than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_MAX)
    else $error("entry count exceeds list depth");

  // A full result is only given when the list really is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status_r == ST_FULL) |-> count_r == CNT_MAX)
    else $error("list full reported with room left");

  // A victim key only accompanies an eviction, and outside an eviction the percent stays in range.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_EVICTED) |->
      (out_data_r[7:0] == 8'd0 && out_data_r[14:8] <= PCT_FULL))
    else $error("bad victim key or percent in result");
`endif

endmodule

/* tb/lmk_checker.sv */
module lmk_checker
  import lmk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // tdata: app_key[7:0], mem_total[43:8], mem_avail[79:44].
  input  logic [79:0]            in_tdata,
  // tuser: action[1:0].
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: victim_key[7:0], free_percent[14:8], entry_count[19:15], zero[23:20].
  input  logic [23:0]            out_tdata,
  // tuser: status[2:0].
  input  logic [2:0]             out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PCT_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                 status;
    logic [KEY_FIELD_W-1:0]  victim;
    logic [PCT_W-1:0]        pct;
    logic [CNT_FIELD_W-1:0]  count;
  } lmk_result_t;

  // Shadow copy of the recency list, oldest key at index zero.
  logic [KEY_FIELD_W-1:0] recency [MAX_ENTRIES_DEF];
  int                     key_count;
  logic [PCT_W-1:0]       kill_pct;
  logic [PCT_W-1:0]       warn_pct;
  lmk_result_t            expected_q [$];
  lmk_result_t            got;
  lmk_result_t            want;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Position of a key in the list, or the entry count when it is absent.
  function automatic int find_key(input logic [KEY_FIELD_W-1:0] key);
    for (int i = 0; i < key_count; i++) begin
      if (recency[i] == key) return i;
    end
    return key_count;
  endfunction

  // Delete one entry and close the gap behind it.
  function automatic void drop_at(input int pos);
    for (int i = pos; i + 1 < key_count; i++) begin
      recency[i] = recency[i + 1];
    end
    key_count--;
  endfunction

  // Applies one request to the shadow list and returns the result it must give.
  function automatic lmk_result_t predict_result(input action_t act,
                                                 input logic [KEY_FIELD_W-1:0] key,
                                                 input logic [KB_W-1:0] total,
                                                 input logic [KB_W-1:0] avail);
    lmk_result_t res;
    int          pos;
    logic [63:0] scaled;
    logic [63:0] quot;
    res        = '0;
    res.status = ST_OK;
    case (act)
      ACT_TOUCH: begin
        pos = find_key(key);
        if (pos < key_count) begin
          drop_at(pos);
          recency[key_count] = key;
          key_count++;
        end else if (key_count >= MAX_ENTRIES_DEF) begin
          res.status = ST_FULL;
        end else begin
          recency[key_count] = key;
          key_count++;
        end
      end
      ACT_REMOVE: begin
        pos = find_key(key);
        if (pos < key_count) drop_at(pos);
      end
      ACT_CHECK: begin
        if (total == '0) begin
          res.status = ST_INVALID;
        end else begin
          scaled  = 64'(avail) * 64'(PCT_FULL);
          quot    = scaled / 64'(total);
          res.pct = (quot > 64'(PCT_FULL)) ? PCT_FULL : quot[PCT_W-1:0];
          // The kill threshold wins when both are crossed.
          if (res.pct < kill_pct) begin
            if (key_count > 0) begin
              res.victim = recency[0];
              drop_at(0);
              res.status = ST_EVICTED;
            end else begin
              res.status = ST_CRITICAL;
            end
          end else if (res.pct < warn_pct) begin
            res.status = ST_WARN;
          end
        end
      end
      default: ;
    endcase
    res.count = key_count[CNT_FIELD_W-1:0];
    return res;
  endfunction

  // A result at an edge always belongs to an earlier request, so results are
  // matched before the request accepted at the same edge is queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      key_count  = 0;
      kill_pct   = KILL_RESET;
      warn_pct   = WARN_RESET;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.victim = out_tdata[7:0];
        got.pct    = out_tdata[14:8];
        got.count  = out_tdata[19:15];
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected, status %0d", out_tuser));
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.victim !== want.victim)
            report_mismatch($sformatf("victim_key %0d, expected %0d", got.victim, want.victim));
          if (got.pct !== want.pct)
            report_mismatch($sformatf("free_percent %0d, expected %0d", got.pct, want.pct));
          if (got.count !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", got.count, want.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KILL) kill_pct = cfg_data;
        else if (cfg_index == REG_WARN) warn_pct = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_result(action_t'(in_tuser), in_tdata[7:0],
                                            in_tdata[43:8], in_tdata[79:44]));
      end
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  import lmk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [KB_W-1:0] KB_MAX = {KB_W{1'b1}};
  // Indexes that name no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // tdata: app_key[7:0], mem_total[43:8], mem_avail[79:44].
  logic [79:0]          in_tdata;
  // tuser: action[1:0].
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // tdata: victim_key[7:0], free_percent[14:8], entry_count[19:15], zero[23:20].
  logic [23:0]          out_tdata;
  // tuser: status[2:0].
  logic [2:0]           out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PCT_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  int                   stall_left;
  logic                 calm;
  logic [KEY_FIELD_W-1:0] pool_base;

  lru_low_memory_killer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lmk_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KB_W-1:0] rand_kb();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KB_W-1:0];
  endfunction

  // Result side back-pressure.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Presents one request after a random gap and returns once it is taken.
  task automatic send_req(input action_t act, input logic [KEY_FIELD_W-1:0] key,
                          input logic [KB_W-1:0] total, input logic [KB_W-1:0] avail);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {avail, total, key};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Thresholds change only once every result is back.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One threshold setting followed by random traffic. Keys mostly come from a
  // pool a little larger than the list so that hits, misses and a full list
  // all happen often.
  task automatic run_phase(input logic [PCT_W-1:0] kill, input logic [PCT_W-1:0] warn,
                           input logic quiet, input int count);
    int               r;
    int               m;
    int               p;
    action_t          act;
    logic [KEY_FIELD_W-1:0] key;
    logic [KB_W-1:0]  total;
    logic [KB_W-1:0]  avail;
    logic [63:0]      scaled;
    wait_idle();
    write_reg(REG_KILL, kill);
    write_reg(REG_WARN, warn);
    calm      = quiet;
    pool_base = KEY_FIELD_W'($urandom);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45) act = ACT_TOUCH;
      else if (r < 65) act = ACT_REMOVE;
      else if (r < 95) act = ACT_CHECK;
      else act = ACT_NOP;
      if ($urandom_range(0, 4) == 0) key = KEY_FIELD_W'($urandom);
      else key = pool_base + KEY_FIELD_W'($urandom_range(0, 19));
      total = rand_kb() >> $urandom_range(0, KB_W - 1);
      avail = rand_kb();
      if (act == ACT_CHECK) begin
        m = $urandom_range(0, 99);
        if (m < 5) begin
          total = '0;
        end else if (m < 75) begin
          // Aim near a chosen percent so both thresholds see both sides.
          if (total == '0) total = KB_W'(1);
          p      = $urandom_range(0, 110);
          scaled = 64'(total) * 64'(p) / 64'(PCT_FULL);
          avail  = scaled[KB_W-1:0] + KB_W'($urandom_range(0, 2));
        end else if (m >= 90) begin
          avail = KB_MAX;
          if ($urandom_range(0, 1) == 0) total = KB_MAX;
        end
      end
      send_req(act, key, total, avail);
    end
  endtask

  initial begin
    int k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_TOUCH;
    cfg_valid = 1'b0;
    cfg_index = REG_KILL;
    cfg_data  = '0;
    calm      = 1'b0;
    pool_base = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset thresholds.
    send_req(ACT_CHECK, '0, '0, KB_MAX);          // invalid total
    send_req(ACT_CHECK, '0, KB_MAX, '0);          // critical with an empty list
    send_req(ACT_TOUCH, 8'h00, '0, '0);
    send_req(ACT_TOUCH, 8'hFF, KB_MAX, KB_MAX);
    send_req(ACT_TOUCH, 8'h00, '0, '0);           // present key moves to the tail
    send_req(ACT_REMOVE, 8'h55, '0, '0);          // absent key, nothing changes
    send_req(ACT_REMOVE, 8'hFF, '0, '0);
    send_req(ACT_NOP, 8'hFF, KB_MAX, KB_MAX);
    for (k = 1; k < MAX_ENTRIES_DEF; k++) send_req(ACT_TOUCH, KEY_FIELD_W'(k), '0, '0);
    send_req(ACT_TOUCH, 8'hAA, '0, '0);           // new key with the list full
    send_req(ACT_CHECK, '0, KB_W'(1), KB_MAX);    // percent saturates at 100
    send_req(ACT_CHECK, '0, KB_W'(100), KB_W'(5));  // evicts the oldest key
    send_req(ACT_CHECK, '0, KB_W'(100), KB_W'(15)); // warning only
    send_req(ACT_CHECK, '0, KB_W'(100), KB_W'(10)); // exactly at the kill threshold

    // Writes to indexes without a register.
    wait_idle();
    write_reg(REG_SPARE_A, PCT_W'($urandom));
    write_reg(REG_SPARE_B, PCT_W'($urandom));

    run_phase(7'd0, 7'd0, 1'b0, 175);
    run_phase(7'd127, 7'd127, 1'b0, 175);
    run_phase(7'd30, 7'd60, 1'b1, 175);
    run_phase(7'd100, 7'd100, 1'b0, 175);
    run_phase(7'd60, 7'd30, 1'b0, 175);
    run_phase(PCT_W'($urandom_range(0, 127)), PCT_W'($urandom_range(0, 127)), 1'b0, 175);
    run_phase(PCT_W'($urandom_range(0, 100)), PCT_W'($urandom_range(0, 100)), 1'b1, 175);
    run_phase(KILL_RESET, WARN_RESET, 1'b0, 175);

    // Drain, then leave room for any stray result.
    in_tvalid = 1'b0;
    calm      = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/lmk_pkg.sv
src/lru_low_memory_killer_core.sv
tb/lmk_checker.sv
tb/tb.sv
